@@ rtl/ghn_pkg.sv @@
// Shared constants, command codes and control/status structs for the grey histogram block.
// No dependencies; every other file of the block but ghn_ram uses it by scoped names.
`default_nettype none
package ghn_pkg;

  localparam int BINS       = 256;
  localparam int BIN_BITS   = $clog2(BINS);
  localparam int COUNT_BITS = 22;
  localparam int FS_BITS    = 10;
  localparam int NUM_BITS   = COUNT_BITS + FS_BITS;
  localparam int DCNT_BITS  = $clog2(NUM_BITS + 1);

  localparam logic [FS_BITS-1:0]    FULL_SCALE_RESET = FS_BITS'(300);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX        = {COUNT_BITS{1'b1}};

  localparam logic [1:0] CMD_COUNT = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic sel_pixel;
    logic clear;
    logic inc;
    logic mult;
    logic div_step;
    logic load_out;
  } ghn_cmd_t;

  typedef struct packed {
    logic div_done;
  } ghn_status_t;

endpackage
`default_nettype wire

@@ rtl/grey_histogram_normalizer_core.sv @@
// Top level of the grey histogram block: joins the controller and the datapath.
// Depends on ghn_pkg, ghn_ctrl, ghn_dp and ghn_ram.
//
// Usage: requests enter on in_valid/in_ready with cmd, pixel_value and bin_index.
// A count request adds one to a 256-entry histogram of 22-bit saturating counters
// and keeps the largest count as the peak; it occupies the block while the bin is
// read from the RAM and written back. A clear request leaves the block ready:
// every bin is marked empty at once by per-bin valid flags; no sweep is needed.
// A read request yields one result on out_valid/out_ready carrying the bin count,
// the peak and the bar height round(count * full_scale / peak), ties to even.
// A read passes through the multiply, 32 steps of the bit-serial divider at one
// quotient bit each and a state to leave the divider, then loads the result
// register. The block takes a new request once the result register is loaded.
// The result register lets count and clear requests be taken while a result
// waits; a further read holds the block at its last cycle until the receiver
// takes the waiting result.
// The user must write full_scale through cfg_we/cfg_wdata only while the block is
// idle; the block does not enforce this. Reset empties the histogram, zeroes the
// peak, sets full_scale to 300 and leaves the block ready with no result pending.
`default_nettype none
module grey_histogram_normalizer_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ghn_pkg::FS_BITS-1:0]    cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     cmd,
  input  wire logic [ghn_pkg::BIN_BITS-1:0]   pixel_value,
  input  wire logic [ghn_pkg::BIN_BITS-1:0]   bin_index,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [ghn_pkg::COUNT_BITS-1:0] bin_count,
  output logic      [ghn_pkg::COUNT_BITS-1:0] peak_count,
  output logic      [ghn_pkg::FS_BITS-1:0]    bar_height
);

  ghn_pkg::ghn_cmd_t    ctl;
  ghn_pkg::ghn_status_t status;

  ghn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .ctl      (ctl)
  );

  ghn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pixel_value(pixel_value),
    .bin_index  (bin_index),
    .bin_count  (bin_count),
    .peak_count (peak_count),
    .bar_height (bar_height)
  );

endmodule
`default_nettype wire

@@ rtl/ghn_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`default_nettype none
module ghn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/ghn_ctrl.sv @@
// Controller state machine for the grey histogram block: handshakes and sequencing.
// Depends on ghn_pkg.
`default_nettype none
module ghn_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          cmd,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire ghn_pkg::ghn_status_t status,
  output ghn_pkg::ghn_cmd_t        ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT_WR,
    S_RD_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == ghn_pkg::CMD_COUNT) begin
            ctl.rd_en     = 1'b1;
            ctl.sel_pixel = 1'b1;
          end else if (cmd == ghn_pkg::CMD_READ) begin
            ctl.rd_en = 1'b1;
          end else if (cmd == ghn_pkg::CMD_CLEAR) begin
            ctl.clear = 1'b1;
          end
        end
      end
      S_CNT_WR: ctl.inc = 1'b1;
      S_RD_MUL: ctl.mult = 1'b1;
      S_DIV:    ctl.div_step = !status.div_done;
      S_DONE:   ctl.load_out = !out_valid || out_ready;
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && cmd == ghn_pkg::CMD_COUNT) begin
            state    <= S_CNT_WR;
            in_ready <= 1'b0;
          end else if (accept && cmd == ghn_pkg::CMD_READ) begin
            state    <= S_RD_MUL;
            in_ready <= 1'b0;
          end
        end
        S_CNT_WR: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
        S_RD_MUL: state <= S_DIV;
        S_DIV: begin
          if (status.div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (ctl.load_out) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/ghn_dp.sv @@
// Datapath of the grey histogram block: bin store, peak, scaling multiplier,
// bit-serial divider and output register. Depends on ghn_pkg and ghn_ram.
`default_nettype none
module ghn_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ghn_pkg::ghn_cmd_t                   ctl,
  output ghn_pkg::ghn_status_t                     status,
  input  wire logic                                cfg_we,
  input  wire logic [ghn_pkg::FS_BITS-1:0]         cfg_wdata,
  input  wire logic [ghn_pkg::BIN_BITS-1:0]        pixel_value,
  input  wire logic [ghn_pkg::BIN_BITS-1:0]        bin_index,
  output logic      [ghn_pkg::COUNT_BITS-1:0]      bin_count,
  output logic      [ghn_pkg::COUNT_BITS-1:0]      peak_count,
  output logic      [ghn_pkg::FS_BITS-1:0]         bar_height
);

  localparam int CB = ghn_pkg::COUNT_BITS;
  localparam int NB = ghn_pkg::NUM_BITS;
  localparam int FB = ghn_pkg::FS_BITS;

  logic [FB-1:0]                    full_scale;
  logic [CB-1:0]                    peak;
  logic [ghn_pkg::BINS-1:0]         bin_valid;
  logic [ghn_pkg::BIN_BITS-1:0]     addr_in;
  logic [ghn_pkg::BIN_BITS-1:0]     addr_q;
  logic [CB-1:0]                    ram_rdata;
  logic [CB-1:0]                    count_eff;
  logic [CB-1:0]                    count_inc;
  logic [CB-1:0]                    count_q;
  logic [NB-1:0]                    quo;
  logic [CB:0]                      rem;
  logic [CB:0]                      trial;
  logic                             trial_ge;
  logic [ghn_pkg::DCNT_BITS-1:0]    div_cnt;
  logic [CB:0]                      twice_rem;
  logic                             round_up;
  logic [FB-1:0]                    height;

  assign addr_in   = ctl.sel_pixel ? pixel_value : bin_index;
  assign count_eff = bin_valid[addr_q] ? ram_rdata : '0;
  assign count_inc = (count_eff == ghn_pkg::COUNT_MAX) ? count_eff : count_eff + CB'(1);

  ghn_ram #(
    .WIDTH(CB),
    .DEPTH(ghn_pkg::BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ctl.inc),
    .waddr(addr_q),
    .wdata(count_inc),
    .re   (ctl.rd_en),
    .raddr(addr_in),
    .rdata(ram_rdata)
  );

  assign trial     = {rem[CB-1:0], quo[NB-1]};
  assign trial_ge  = trial >= {1'b0, peak};
  assign twice_rem = {rem[CB-1:0], 1'b0};
  assign round_up  = (twice_rem > {1'b0, peak}) ||
                     ((twice_rem == {1'b0, peak}) && quo[0]);
  assign height    = (peak == '0) ? '0 : quo[FB-1:0] + FB'(round_up);
  assign status.div_done = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= ghn_pkg::FULL_SCALE_RESET;
      peak       <= '0;
      bin_valid  <= '0;
    end else begin
      if (cfg_we) begin
        full_scale <= cfg_wdata;
      end
      if (ctl.clear) begin
        peak      <= '0;
        bin_valid <= '0;
      end else if (ctl.inc) begin
        bin_valid[addr_q] <= 1'b1;
        if (count_inc > peak) begin
          peak <= count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      addr_q <= addr_in;
    end
    if (ctl.mult) begin
      count_q <= count_eff;
      quo     <= NB'(count_eff) * NB'(full_scale);
      rem     <= '0;
      div_cnt <= ghn_pkg::DCNT_BITS'(NB);
    end else if (ctl.div_step) begin
      rem     <= trial_ge ? trial - {1'b0, peak} : trial;
      quo     <= {quo[NB-2:0], trial_ge};
      div_cnt <= div_cnt - ghn_pkg::DCNT_BITS'(1);
    end
    if (ctl.load_out) begin
      bin_count  <= count_q;
      peak_count <= peak;
      bar_height <= height;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ghn_checker.sv @@
// Port-level checker for the grey histogram block, bound to its top level.
// Depends on ghn_pkg and grey_histogram_normalizer_core.
`default_nettype none
module ghn_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           cfg_we,
  input wire logic [ghn_pkg::FS_BITS-1:0]    cfg_wdata,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [1:0]                     cmd,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ghn_pkg::COUNT_BITS-1:0] bin_count,
  input wire logic [ghn_pkg::COUNT_BITS-1:0] peak_count,
  input wire logic [ghn_pkg::FS_BITS-1:0]    bar_height
);

  logic [ghn_pkg::FS_BITS-1:0] fs_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_shadow <= ghn_pkg::FULL_SCALE_RESET;
    end else if (cfg_we) begin
      fs_shadow <= cfg_wdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_count) && $stable(bar_height))
    else $error("Result changed while stalled.");

  a_count_le_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_count <= peak_count)
    else $error("Bin count exceeds peak.");

  a_height_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_count == '0 && bar_height == '0) ||
                  (peak_count != '0 && bar_height <= fs_shadow))
    else $error("Bar height out of range.");

  a_peak_bin_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && peak_count != '0 && bin_count == peak_count |-> bar_height == fs_shadow)
    else $error("Peak bin does not reach full scale.");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == ghn_pkg::CMD_READ |=> !in_ready)
    else $error("Block took a request during a read.");

endmodule

bind grey_histogram_normalizer_core ghn_checker u_ghn_checker (.*);
`default_nettype wire
